// ===== hw/rtl/spl_pkg.sv =====
// Shared types, codes and state encoding for the sorted priority list.
package spl_pkg;

	// Payload types of one stored entry.
	typedef logic [15:0] tag_t;
	typedef logic signed [16:0] key_t;

	// Operation codes carried in the mode field.
	typedef enum logic [2:0] {
		MODE_APPEND = 3'd0,
		MODE_INSERT = 3'd1,
		MODE_READ   = 3'd2,
		MODE_POP    = 3'd3,
		MODE_REKEY  = 3'd4
	} mode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ_WAIT,
		ST_POP_WAIT,
		ST_SCAN_TAG,
		ST_REMOVE,
		ST_UP_MV,
		ST_INS_START,
		ST_SCAN_KEY,
		ST_DN_MV,
		ST_PUT,
		ST_FINISH
	} state_t;

	// Flags from the shared compare unit.
	typedef struct packed {
		logic tag_eq;
		logic gt;
		logic lt;
	} cmp_res_t;

endpackage

// ===== hw/rtl/sorted_priority_list_top.sv =====
// Top level of the sorted priority list: sequencer, entry store and compare unit.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | mode, tag, score, side_negative, position
//  out     | out_valid / out_ready| status, tag_out, key_out, count
//
// One word is processed at a time; the entry store has a single read port and one
// compare is done per cycle, so each cycle walks one entry. in_ready is high in the
// idle state only.
// The result sits in an output register, so a new word is accepted while it waits.
// The sequencer stalls in its last step until that register is free.
// Reset clears the count and the control state; no clearing pass is needed.
module sorted_priority_list_top #(
	parameter int CAPACITY = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          mode,
	input  logic [15:0]         tag,
	input  logic signed [15:0]  score,
	input  logic                side_negative,
	input  logic [3:0]          position,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [15:0]         tag_out,
	output logic signed [16:0]  key_out,
	output logic [3:0]          count
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = CW + 1;
	localparam int PW = (CW > 4) ? CW : 4;

	spl_pkg::state_t  state_q, state_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [IW-1:0]    idx_q, idx_d;
	logic [IW-1:0]    p_q, p_d;
	spl_pkg::status_t stat_q, stat_d;
	spl_pkg::tag_t    rtag_q, rtag_d;
	spl_pkg::key_t    rkey_q, rkey_d;

	logic [2:0]       mode_q;
	spl_pkg::tag_t    tag_q;
	spl_pkg::key_t    key_q;
	logic [3:0]       pos_q;

	logic             we, re, out_load, full;
	logic [IW-1:0]    waddr, raddr;
	spl_pkg::tag_t    wtag, rd_tag;
	spl_pkg::key_t    wkey, rd_key;
	spl_pkg::cmp_res_t cmp;
	spl_pkg::state_t  after_rm;
	logic             stop;
	spl_pkg::key_t    s_ext;

	logic             out_vld_q;
	spl_pkg::status_t status_q;
	spl_pkg::tag_t    tag_out_q;
	spl_pkg::key_t    key_out_q;
	logic [3:0]       count_q;

	assign in_ready  = (state_q == spl_pkg::ST_IDLE);
	assign out_valid = out_vld_q;
	assign status    = status_q;
	assign tag_out   = tag_out_q;
	assign key_out   = key_out_q;
	assign count     = count_q;

	assign full     = (cnt_q == CW'(CAPACITY));
	assign after_rm = (mode_q == spl_pkg::MODE_POP) ? spl_pkg::ST_FINISH
	                                                : spl_pkg::ST_INS_START;
	assign stop     = (idx_q == '0) ? cmp.lt : !cmp.gt;
	assign s_ext    = {score[15], score};

	spl_store #(.CAPACITY(CAPACITY)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wtag  (wtag),
		.wkey  (wkey),
		.re    (re),
		.raddr (raddr),
		.rtag  (rd_tag),
		.rkey  (rd_key)
	);

	spl_cmp u_cmp (
		.ent_tag (rd_tag),
		.ent_key (rd_key),
		.ref_tag (tag_q),
		.ref_key (key_q),
		.res     (cmp)
	);

	// Sequencer: next state, store accesses and result capture.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		p_d      = p_q;
		stat_d   = stat_q;
		rtag_d   = rtag_q;
		rkey_d   = rkey_q;
		we       = 1'b0;
		waddr    = idx_q;
		wtag     = tag_q;
		wkey     = key_q;
		re       = 1'b0;
		raddr    = idx_q;
		out_load = 1'b0;
		unique case (state_q)
			spl_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = spl_pkg::ST_DECODE;
					stat_d  = spl_pkg::STAT_OK;
					rtag_d  = '0;
					rkey_d  = '0;
				end
			end
			spl_pkg::ST_DECODE: begin
				unique case (mode_q)
					spl_pkg::MODE_APPEND: begin
						if (full) begin
							stat_d = spl_pkg::STAT_FULL;
						end else begin
							we    = 1'b1;
							waddr = IW'(cnt_q);
							cnt_d = cnt_q + CW'(1);
						end
						state_d = spl_pkg::ST_FINISH;
					end
					spl_pkg::MODE_INSERT: begin
						if (full) begin
							stat_d  = spl_pkg::STAT_FULL;
							state_d = spl_pkg::ST_FINISH;
						end else begin
							state_d = spl_pkg::ST_INS_START;
						end
					end
					spl_pkg::MODE_READ: begin
						if (PW'(pos_q) >= PW'(cnt_q)) begin
							stat_d  = spl_pkg::STAT_MISS;
							state_d = spl_pkg::ST_FINISH;
						end else begin
							re      = 1'b1;
							raddr   = IW'(pos_q);
							state_d = spl_pkg::ST_READ_WAIT;
						end
					end
					spl_pkg::MODE_POP, spl_pkg::MODE_REKEY: begin
						if (cnt_q == '0) begin
							stat_d  = spl_pkg::STAT_MISS;
							state_d = spl_pkg::ST_FINISH;
						end else begin
							re      = 1'b1;
							raddr   = '0;
							idx_d   = '0;
							state_d = (mode_q == spl_pkg::MODE_POP) ? spl_pkg::ST_POP_WAIT
							                                        : spl_pkg::ST_SCAN_TAG;
						end
					end
					default: begin
						stat_d  = spl_pkg::STAT_MISS;
						state_d = spl_pkg::ST_FINISH;
					end
				endcase
			end
			spl_pkg::ST_READ_WAIT: begin
				rtag_d  = rd_tag;
				rkey_d  = rd_key;
				state_d = spl_pkg::ST_FINISH;
			end
			spl_pkg::ST_POP_WAIT: begin
				rtag_d  = rd_tag;
				rkey_d  = rd_key;
				state_d = spl_pkg::ST_REMOVE;
			end
			spl_pkg::ST_SCAN_TAG: begin
				if (cmp.tag_eq) begin
					state_d = spl_pkg::ST_REMOVE;
				end else if (EW'(idx_q) + EW'(1) >= EW'(cnt_q)) begin
					stat_d  = spl_pkg::STAT_MISS;
					state_d = spl_pkg::ST_FINISH;
				end else begin
					re    = 1'b1;
					raddr = idx_q + IW'(1);
					idx_d = idx_q + IW'(1);
				end
			end
			spl_pkg::ST_REMOVE: begin
				if (EW'(idx_q) + EW'(1) >= EW'(cnt_q)) begin
					cnt_d   = cnt_q - CW'(1);
					state_d = after_rm;
				end else begin
					re      = 1'b1;
					raddr   = idx_q + IW'(1);
					state_d = spl_pkg::ST_UP_MV;
				end
			end
			spl_pkg::ST_UP_MV: begin
				// Close the gap: each entry moves one place towards the head.
				we    = 1'b1;
				waddr = idx_q;
				wtag  = rd_tag;
				wkey  = rd_key;
				idx_d = idx_q + IW'(1);
				if (EW'(idx_q) + EW'(2) < EW'(cnt_q)) begin
					re    = 1'b1;
					raddr = IW'(EW'(idx_q) + EW'(2));
				end else begin
					cnt_d   = cnt_q - CW'(1);
					state_d = after_rm;
				end
			end
			spl_pkg::ST_INS_START: begin
				if (cnt_q == '0) begin
					p_d     = '0;
					state_d = spl_pkg::ST_PUT;
				end else begin
					re      = 1'b1;
					raddr   = '0;
					idx_d   = '0;
					state_d = spl_pkg::ST_SCAN_KEY;
				end
			end
			spl_pkg::ST_SCAN_KEY: begin
				// The head is passed only if its key is not smaller; later ones if greater.
				if (stop) begin
					p_d     = idx_q;
					re      = 1'b1;
					raddr   = IW'(cnt_q - CW'(1));
					idx_d   = IW'(cnt_q - CW'(1));
					state_d = spl_pkg::ST_DN_MV;
				end else if (EW'(idx_q) + EW'(1) >= EW'(cnt_q)) begin
					p_d     = IW'(cnt_q);
					state_d = spl_pkg::ST_PUT;
				end else begin
					re    = 1'b1;
					raddr = idx_q + IW'(1);
					idx_d = idx_q + IW'(1);
				end
			end
			spl_pkg::ST_DN_MV: begin
				// Open a slot: entries from the tail down to the slot move one place back.
				we    = 1'b1;
				waddr = idx_q + IW'(1);
				wtag  = rd_tag;
				wkey  = rd_key;
				if (idx_q == p_q) begin
					state_d = spl_pkg::ST_PUT;
				end else begin
					re    = 1'b1;
					raddr = idx_q - IW'(1);
					idx_d = idx_q - IW'(1);
				end
			end
			spl_pkg::ST_PUT: begin
				we      = 1'b1;
				waddr   = p_q;
				cnt_d   = cnt_q + CW'(1);
				state_d = spl_pkg::ST_FINISH;
			end
			spl_pkg::ST_FINISH: begin
				if (!out_vld_q || out_ready) begin
					out_load = 1'b1;
					state_d  = spl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spl_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spl_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Working registers of the operation in progress.
	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		p_q    <= p_d;
		stat_q <= stat_d;
		rtag_q <= rtag_d;
		rkey_q <= rkey_d;
		if (in_valid && in_ready) begin
			mode_q <= mode;
			tag_q  <= tag;
			key_q  <= side_negative ? -s_ext : s_ext;
			pos_q  <= position;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q  <= stat_q;
			tag_out_q <= rtag_q;
			key_out_q <= rkey_q;
			count_q   <= 4'(cnt_q);
		end
	end

	// Reads only ever touch entries that are held.
	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		re |-> (EW'(raddr) < EW'(cnt_q)))
		else $error("entry store read beyond held entries");

	// Writes never land more than one place past the tail.
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (EW'(waddr) <= EW'(cnt_q)))
		else $error("entry store write beyond tail");

	// The store is left alone while idle or holding a result.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spl_pkg::ST_IDLE || state_q == spl_pkg::ST_FINISH) |-> !we)
		else $error("entry store written outside an operation");

	// The count moves by at most one per cycle and never passes the capacity.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CW'(1) ||
		           cnt_q == $past(cnt_q) - CW'(1)) && (EW'(cnt_q) <= EW'(CAPACITY))))
		else $error("entry count out of step");

endmodule

// ===== hw/rtl/spl_store.sv =====
// Entry store: tag and key memory with one write port and one registered read port.
module spl_store #(
	parameter int CAPACITY = 8,
	localparam int IW = $clog2(CAPACITY)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  spl_pkg::tag_t wtag,
	input  spl_pkg::key_t wkey,
	input  logic          re,
	input  logic [IW-1:0] raddr,
	output spl_pkg::tag_t rtag,
	output spl_pkg::key_t rkey
);

	spl_pkg::tag_t tag_mem [CAPACITY];
	spl_pkg::key_t key_mem [CAPACITY];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			tag_mem[waddr] <= wtag;
			key_mem[waddr] <= wkey;
		end
	end

	// Read port, data registered and available in the cycle after the request.
	always_ff @(posedge clk) begin
		if (re) begin
			rtag <= tag_mem[raddr];
			rkey <= key_mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/spl_cmp.sv =====
// Shared compare unit: checks one stored entry against the word being processed.
module spl_cmp (
	input  spl_pkg::tag_t     ent_tag,
	input  spl_pkg::key_t     ent_key,
	input  spl_pkg::tag_t     ref_tag,
	input  spl_pkg::key_t     ref_key,
	output spl_pkg::cmp_res_t res
);

	// Signed compare of keys and equality of tags.
	always_comb begin
		res.tag_eq = (ent_tag == ref_tag);
		res.gt     = (ent_key > ref_key);
		res.lt     = (ent_key < ref_key);
	end

endmodule

// ===== tb/spl_checker.sv =====
// Checker for the sorted priority list: mirrors the entry list and compares every result word.
module spl_checker #(
	parameter int CAPACITY = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         mode,
	input  logic [15:0]        tag,
	input  logic signed [15:0] score,
	input  logic               side_negative,
	input  logic [3:0]         position,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic [15:0]        tag_out,
	input  logic signed [16:0] key_out,
	input  logic [3:0]         count,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		spl_pkg::status_t status;
		spl_pkg::tag_t    tag;
		spl_pkg::key_t    key;
		logic [3:0]       count;
	} list_result_t;

	// Mirror of the entry list, head at index zero.
	spl_pkg::tag_t held_tags [CAPACITY];
	spl_pkg::key_t held_keys [CAPACITY];
	int            held_count;
	list_result_t  awaited_results [$];

	// The ordering key is the score with the side sign applied.
	function automatic spl_pkg::key_t ordering_key(logic signed [15:0] s, logic neg);
		spl_pkg::key_t k;
		k = spl_pkg::key_t'(s);
		return neg ? -k : k;
	endfunction

	// Open a gap at the given slot and store the entry there.
	function automatic void place_entry(int slot, spl_pkg::tag_t t, spl_pkg::key_t k);
		for (int i = held_count; i > slot; i--) begin
			held_tags[i] = held_tags[i - 1];
			held_keys[i] = held_keys[i - 1];
		end
		held_tags[slot] = t;
		held_keys[slot] = k;
		held_count++;
	endfunction

	// Close the gap left by the entry at the given slot.
	function automatic void drop_entry(int slot);
		for (int i = slot; i + 1 < held_count; i++) begin
			held_tags[i] = held_tags[i + 1];
			held_keys[i] = held_keys[i + 1];
		end
		held_count--;
	endfunction

	// Head if the head key is smaller, else after the run of greater keys behind the head.
	function automatic void insert_by_key(spl_pkg::tag_t t, spl_pkg::key_t k);
		int slot;
		if (held_count == 0 || held_keys[0] < k) begin
			slot = 0;
		end else begin
			slot = 1;
			while (slot < held_count && held_keys[slot] > k)
				slot++;
		end
		place_entry(slot, t, k);
	endfunction

	// Apply one input word to the mirror and return the result word it should produce.
	function automatic list_result_t apply_word(logic [2:0] m, spl_pkg::tag_t t,
			logic signed [15:0] s, logic neg, logic [3:0] pos);
		list_result_t  r;
		spl_pkg::key_t k;
		int            slot;
		r.status = spl_pkg::STAT_OK;
		r.tag    = '0;
		r.key    = '0;
		k = ordering_key(s, neg);
		case (m)
			spl_pkg::MODE_APPEND: begin
				if (held_count >= CAPACITY)
					r.status = spl_pkg::STAT_FULL;
				else
					place_entry(held_count, t, k);
			end
			spl_pkg::MODE_INSERT: begin
				if (held_count >= CAPACITY)
					r.status = spl_pkg::STAT_FULL;
				else
					insert_by_key(t, k);
			end
			spl_pkg::MODE_READ: begin
				if (int'(pos) >= held_count) begin
					r.status = spl_pkg::STAT_MISS;
				end else begin
					r.tag = held_tags[pos];
					r.key = held_keys[pos];
				end
			end
			spl_pkg::MODE_POP: begin
				if (held_count == 0) begin
					r.status = spl_pkg::STAT_MISS;
				end else begin
					r.tag = held_tags[0];
					r.key = held_keys[0];
					drop_entry(0);
				end
			end
			spl_pkg::MODE_REKEY: begin
				slot = 0;
				while (slot < held_count && held_tags[slot] != t)
					slot++;
				if (slot >= held_count) begin
					r.status = spl_pkg::STAT_MISS;
				end else begin
					drop_entry(slot);
					insert_by_key(t, k);
				end
			end
			default: begin
				r.status = spl_pkg::STAT_MISS;
			end
		endcase
		r.count = held_count[3:0];
		return r;
	endfunction

	function automatic void report_mismatch(string field, logic signed [31:0] want,
			logic signed [31:0] got);
		errors++;
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
	endfunction

	// Compare the result word leaving the block, then record the one for the word entering.
	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			held_count = 0;
			awaited_results.delete();
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word: expected none, actual status %0d tag %h key %0d count %0d",
						$time, status, tag_out, key_out, count);
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status)
						report_mismatch("status", want.status, status);
					if (tag_out !== want.tag)
						report_mismatch("tag_out", want.tag, tag_out);
					if (key_out !== want.key)
						report_mismatch("key_out", want.key, key_out);
					if (count !== want.count)
						report_mismatch("count", want.count, count);
				end
			end
			if (in_valid && in_ready)
				awaited_results.push_back(apply_word(mode, tag, score, side_negative, position));
		end
		pending = awaited_results.size();
	end

endmodule

// ===== tb/sorted_priority_list_top_tb.sv =====
// Testbench top for the sorted priority list: clock, reset, word stimulus and verdict.
module sorted_priority_list_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY       = 8;
	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 11;
	localparam int RANDOM_WORDS   = 700;
	localparam int HOLD_CYCLES    = 250;
	localparam int STALL_LIMIT    = 5000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int BIAS_RUN       = 40;
	localparam int TAG_POOL       = 12;
	// Largest value the three-bit mode field can carry.
	localparam int MODE_LAST_CODE = 7;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         mode;
	logic [15:0]        tag;
	logic signed [15:0] score;
	logic               side_negative;
	logic [3:0]         position;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [15:0]        tag_out;
	logic signed [16:0] key_out;
	logic [3:0]         count;

	int fail_count;
	int awaited;
	// 0: sender idles lightly, receiver heavily; 1: the other way round; 2: no idling.
	int idle_phase = 0;

	sorted_priority_list_top #(.CAPACITY(CAPACITY)) DUT (.*);

	spl_checker #(.CAPACITY(CAPACITY)) checker_inst (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .tag(tag), .score(score), .side_negative(side_negative),
		.position(position),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .tag_out(tag_out), .key_out(key_out), .count(count),
		.errors(fail_count), .pending(awaited)
	);

	initial begin
		clk = 1'b0;
		forever #(HALF_PERIOD) clk = ~clk;
	end

	// Offer one word, after a random number of idle cycles, and hold it until accepted.
	task automatic offer_word(logic [2:0] m, logic [15:0] t, logic signed [15:0] s,
			logic neg, logic [3:0] p);
		int idle_pct;
		idle_pct = (idle_phase == 0) ? 36 : (idle_phase == 1) ? 88 : 0;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= m;
		tag           <= t;
		score         <= s;
		side_negative <= neg;
		position      <= p;
		do @(posedge clk); while (!in_ready);
	endtask

	// Receiver: a long hold-off right after reset so the block backs up, then random stalls.
	initial begin
		int idle_pct;
		out_ready <= 1'b0;
		repeat (RESET_CYCLES + HOLD_CYCLES) @(posedge clk);
		forever begin
			@(posedge clk);
			idle_pct = (idle_phase == 0) ? 88 : (idle_phase == 1) ? 36 : 0;
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [2:0]         m;
		logic [15:0]        t;
		logic signed [15:0] s;
		logic [3:0]         p;
		int                 roll;
		bit                 drain;

		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		mode          <= spl_pkg::MODE_APPEND;
		tag           <= '0;
		score         <= '0;
		side_negative <= 1'b0;
		position      <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Empty list: pop, read and rekey all miss; unused modes also miss.
		offer_word(spl_pkg::MODE_POP, 16'h0001, 16'sd0, 1'b0, 4'd0);
		offer_word(spl_pkg::MODE_READ, 16'h0001, 16'sd0, 1'b0, 4'd0);
		offer_word(spl_pkg::MODE_REKEY, 16'h0001, 16'sd5, 1'b0, 4'd0);
		offer_word(3'(spl_pkg::MODE_REKEY + 1), 16'h0001, 16'sd0, 1'b0, 4'd0);
		offer_word(3'(MODE_LAST_CODE), 16'hFFFF, -16'sd1, 1'b1, 4'd15);
		// Key extremes, a new head, and appends that leave the list out of order.
		offer_word(spl_pkg::MODE_INSERT, 16'hFFFF, 16'sd32767, 1'b0, 4'd0);
		offer_word(spl_pkg::MODE_INSERT, 16'h0000, -16'sd32768, 1'b1, 4'd0);
		offer_word(spl_pkg::MODE_APPEND, 16'hAAAA, -16'sd32768, 1'b0, 4'd0);
		offer_word(spl_pkg::MODE_APPEND, 16'h5555, 16'sd100, 1'b0, 4'd0);
		offer_word(spl_pkg::MODE_INSERT, 16'h0003, 16'sd100, 1'b0, 4'd0);
		// A second entry with the same tag, and an insert equal to an existing key.
		offer_word(spl_pkg::MODE_INSERT, 16'hFFFF, 16'sd0, 1'b1, 4'd0);
		offer_word(spl_pkg::MODE_INSERT, 16'h0004, 16'sd32767, 1'b0, 4'd0);
		offer_word(spl_pkg::MODE_APPEND, 16'h0005, -16'sd1, 1'b1, 4'd0);
		// Full list refuses both kinds of insert.
		offer_word(spl_pkg::MODE_APPEND, 16'h0006, 16'sd1, 1'b0, 4'd0);
		offer_word(spl_pkg::MODE_INSERT, 16'h0007, 16'sd1, 1'b0, 4'd0);
		// Reads at the last entry and beyond the count.
		offer_word(spl_pkg::MODE_READ, 16'h0000, 16'sd0, 1'b0, 4'd7);
		offer_word(spl_pkg::MODE_READ, 16'h0000, 16'sd0, 1'b0, 4'd8);
		offer_word(spl_pkg::MODE_READ, 16'h0000, 16'sd0, 1'b0, 4'd15);
		// Rekey on a full list hits the first duplicate; an unknown tag misses.
		offer_word(spl_pkg::MODE_REKEY, 16'hFFFF, -16'sd32768, 1'b0, 4'd0);
		offer_word(spl_pkg::MODE_REKEY, 16'h1234, 16'sd9, 1'b0, 4'd0);
		offer_word(spl_pkg::MODE_POP, 16'h0000, 16'sd0, 1'b0, 4'd0);
		offer_word(spl_pkg::MODE_POP, 16'h0000, 16'sd0, 1'b0, 4'd0);
		offer_word(spl_pkg::MODE_REKEY, 16'h0005, 16'sd32767, 1'b1, 4'd0);
		offer_word(spl_pkg::MODE_READ, 16'h0000, 16'sd0, 1'b0, 4'd0);

		// Random words, alternating runs that fill the list and runs that drain it.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			idle_phase = (i * 3) / RANDOM_WORDS;
			drain      = bit'((i / BIAS_RUN) % 2);
			roll       = $urandom_range(99);
			if (roll < (drain ? 15 : 40))
				m = spl_pkg::MODE_INSERT;
			else if (roll < (drain ? 20 : 55))
				m = spl_pkg::MODE_APPEND;
			else if (roll < (drain ? 40 : 70))
				m = spl_pkg::MODE_READ;
			else if (roll < 80)
				m = spl_pkg::MODE_POP;
			else if (roll < 95)
				m = spl_pkg::MODE_REKEY;
			else
				m = 3'($urandom_range(MODE_LAST_CODE, spl_pkg::MODE_REKEY + 1));

			// A small tag pool makes rekeys and duplicate tags common.
			t = 16'(($urandom_range(99) < 75) ? $urandom_range(TAG_POOL - 1) : $urandom);

			// Narrow scores give many equal keys; some full range and some extremes.
			roll = $urandom_range(99);
			if (roll < 50)
				s = 16'(int'($urandom_range(16)) - 8);
			else if (roll < 85)
				s = 16'($urandom);
			else
				case ($urandom_range(3))
					0:       s = 16'sd32767;
					1:       s = -16'sd32768;
					2:       s = 16'sd0;
					default: s = -16'sd1;
				endcase

			p = 4'(($urandom_range(99) < 75) ? $urandom_range(CAPACITY - 1)
			                                 : $urandom_range(15));
			offer_word(m, t, s, 1'($urandom_range(1)), p);
		end
		in_valid <= 1'b0;

		// Wait for every outstanding result, then give the block time to show strays.
		@(negedge clk);
		while (awaited != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/spl_pkg.sv
hw/rtl/spl_store.sv
hw/rtl/spl_cmp.sv
hw/rtl/sorted_priority_list_top.sv
tb/spl_checker.sv
tb/sorted_priority_list_top_tb.sv
